// ===== sv/awfe_pkg.sv =====
// ----------------------------------------------------------------------------
// awfe_pkg
// Shared types and constants of the accelerometer window feature extractor.
// ----------------------------------------------------------------------------
`default_nettype none

package awfe_pkg;

    // window length, a power of two so the window sums divide by a shift
    localparam int unsigned WINDOW   = 64;

    localparam int unsigned MAG_W    = 22;
    localparam int unsigned SQRT_N   = 22;
    localparam int unsigned RAD_W    = 2 * SQRT_N;
    localparam int unsigned THR_W    = 24;
    localparam int unsigned THR_RST  = 32768;
    localparam logic [THR_W-1:0] PEAK_FLOOR = 24'd98304;

    // reciprocal of WINDOW-1 for the zero-crossing rate, exact for count*65536
    localparam int unsigned ZCR_IN_W  = $clog2(WINDOW) + 16;
    localparam int unsigned ZCR_SH    = ZCR_IN_W + $clog2(WINDOW - 1);
    localparam int unsigned ZCR_RCP_W = ZCR_IN_W + 2;
    localparam logic [ZCR_RCP_W-1:0] ZCR_RCP =
        ZCR_RCP_W'(((64'd1 << ZCR_SH) + 64'(WINDOW - 2)) / 64'(WINDOW - 1));

    localparam logic [3:0] F_MEAN   = 4'd0;
    localparam logic [3:0] F_STD    = 4'd1;
    localparam logic [3:0] F_MAX    = 4'd2;
    localparam logic [3:0] F_MIN    = 4'd3;
    localparam logic [3:0] F_RANGE  = 4'd4;
    localparam logic [3:0] F_ZCR    = 4'd5;
    localparam logic [3:0] F_SMA    = 4'd6;
    localparam logic [3:0] F_PEAKS  = 4'd7;
    localparam logic [3:0] F_PKAMP  = 4'd8;
    localparam logic [3:0] F_STEP   = 4'd9;
    localparam logic [3:0] F_ENERGY = 4'd10;
    localparam logic [3:0] F_ROLL   = 4'd11;
    localparam logic [3:0] F_PITCH  = 4'd12;
    localparam logic [3:0] F_XMEAN  = 4'd13;
    localparam logic [3:0] F_YMEAN  = 4'd14;
    localparam logic [3:0] F_ZMEAN  = 4'd15;

    typedef enum logic [9:0] {
        S_IDLE  = 10'b00_0000_0001,
        S_SQ    = 10'b00_0000_0010,
        S_MSQRT = 10'b00_0000_0100,
        S_WRITE = 10'b00_0000_1000,
        S_WALK1 = 10'b00_0001_0000,
        S_MSQ   = 10'b00_0010_0000,
        S_SQRT2 = 10'b00_0100_0000,
        S_THR   = 10'b00_1000_0000,
        S_WALK2 = 10'b01_0000_0000,
        S_OUT   = 10'b10_0000_0000
    } t_state;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic [MAG_W-1:0]   mag;
    } t_entry;

endpackage

`default_nettype wire

// ===== sv/accel_window_feature_extractor_core.sv =====
// ----------------------------------------------------------------------------
// accel_window_feature_extractor_core
// Window ring of accelerometer samples with magnitude, statistics over the
// window through one squarer and one bit-serial root.
// ----------------------------------------------------------------------------
// Usage: one sample beat enters on the input channel (i_in_valid, o_in_stall).
// The block computes the magnitude with the shared squarer and a 22-step root,
// stores the sample in the ring and compares the magnitude jump against the
// register written through i_cfg_we / i_cfg_data (reset value 0.5 g).
// Once the ring is full and the jump exceeds the threshold, the ring is
// walked twice with one more 22-step root for the deviation in between.
// Window sums divide by a shift, the zero-crossing count by a constant
// reciprocal multiply. Then 16 feature beats leave on the output channel
// (o_out_valid, i_out_stall), the last one flagged. o_in_stall is high
// whenever the block is not idle, so no new sample is taken while a sample
// or its feature beats are in work. A stalled receiver holds the current
// feature beat and the block waits. Reset empties the window and restores
// the threshold; the ring contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module accel_window_feature_extractor_core
    import awfe_pkg::*;
(
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cfg_we,
    input  wire  [21:0]        i_cfg_data,
    input  wire                i_in_valid,
    output logic               o_in_stall,
    input  wire  signed [15:0] i_accel_x,
    input  wire  signed [15:0] i_accel_y,
    input  wire  signed [15:0] i_accel_z,
    input  wire  signed [24:0] i_roll_angle,
    input  wire  signed [24:0] i_pitch_angle,
    output logic               o_out_valid,
    input  wire                i_out_stall,
    output logic [3:0]         o_feature_index,
    output logic signed [31:0] o_feature_value,
    output logic               o_last_feature
);

    localparam int unsigned AW     = $clog2(WINDOW);
    localparam int unsigned LW     = $clog2(WINDOW);
    localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
    localparam int unsigned SUM_W  = MAG_W + LW;
    localparam int unsigned SQS_W  = 2 * MAG_W + LW;
    localparam int unsigned SMA_W  = 18 + LW;
    localparam int unsigned AX_W   = 16 + LW;
    localparam int unsigned STEP_W = $clog2(SQRT_N);
    localparam int unsigned ZP_W   = CNT_W + ZCR_RCP_W;

    // control
    t_state             r_state;
    logic [AW-1:0]      r_slot;
    logic               r_full;
    logic [MAG_W-1:0]   r_prev_mag;
    logic               r_prev_valid;
    logic [MAG_W-1:0]   r_thr;
    logic               r_ovalid;
    logic [3:0]         r_oidx;
    logic [CNT_W-1:0]   r_cnt;
    logic [STEP_W-1:0]  r_step;
    logic [1:0]         r_k;
    logic               r_v1;
    logic               r_v2;

    // datapath
    t_entry             r_mem [WINDOW];
    t_entry             r_rd;
    logic [AW-1:0]      r_addr;
    logic signed [15:0] r_x, r_y, r_z;
    logic signed [24:0] r_roll, r_pitch;
    logic [31:0]        r_acc;
    logic signed [45:0] r_prod;
    logic [RAD_W-1:0]   r_rad;
    logic [24:0]        r_rem;
    logic [SQRT_N-1:0]  r_root;
    logic [SUM_W-1:0]   r_sum;
    logic [SQS_W-1:0]   r_sqs;
    logic [SMA_W-1:0]   r_sma;
    logic signed [AX_W-1:0] r_sx, r_sy, r_sz;
    logic [MAG_W-1:0]   r_max, r_min, r_mstep, r_mprev;
    logic               r_first;
    logic               r_prev_neg;
    logic [CNT_W-1:0]   r_zc, r_peaks;
    logic [SQRT_N-1:0]  r_std;
    logic [THR_W-1:0]   r_thresh;

    logic               in_acc, out_acc, walking, issue;
    logic [AW-1:0]      n_slot, addr_inc;
    logic               n_full, trigger;
    logic [MAG_W-1:0]   jump;
    logic signed [22:0] mul_a;
    logic [31:0]        sq_total;
    logic [24:0]        sq_t, sq_trial, n_rem;
    logic [SQRT_N-1:0]  n_root;
    logic [MAG_W-1:0]   mean_v;
    logic [2*MAG_W-1:0] e32_v;
    logic [ZP_W-1:0]    zc_prod;
    logic [2*MAG_W-1:0] var_v;
    logic [THR_W-1:0]   thr_sum;
    logic [MAG_W-1:0]   mdiff;
    logic               m_neg;

    function automatic logic [16:0] abs16(input logic signed [15:0] v);
        logic signed [16:0] e;
        e = {v[15], v};
        return e[16] ? 17'(-e) : 17'(e);
    endfunction

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_acc  = r_ovalid && !i_out_stall;
    assign walking  = (r_state == S_WALK1) || (r_state == S_WALK2);
    assign issue    = walking && (r_cnt != CNT_W'(WINDOW));
    assign addr_inc = (r_addr == AW'(WINDOW - 1)) ? '0 : r_addr + 1'b1;
    assign n_slot   = (r_slot == AW'(WINDOW - 1)) ? '0 : r_slot + 1'b1;
    assign n_full   = r_full || (r_slot == AW'(WINDOW - 1));

    always_comb begin
        if (!r_prev_valid) begin
            jump = '0;
        end else if (r_root > r_prev_mag) begin
            jump = r_root - r_prev_mag;
        end else begin
            jump = r_prev_mag - r_root;
        end
    end
    assign trigger = n_full && (jump > r_thr);

    // window sums divided by the window length
    assign mean_v  = r_sum[SUM_W-1:LW];
    assign e32_v   = r_sqs[SQS_W-1:LW];
    assign zc_prod = ZP_W'(r_zc) * ZP_W'(ZCR_RCP);

    // shared squarer
    always_comb begin
        unique case (r_state)
            S_SQ: begin
                case (r_k)
                    2'd0:    mul_a = 23'(r_x);
                    2'd1:    mul_a = 23'(r_y);
                    2'd2:    mul_a = 23'(r_z);
                    default: mul_a = '0;
                endcase
            end
            S_WALK1: mul_a = {1'b0, r_rd.mag};
            S_MSQ:   mul_a = {1'b0, mean_v};
            default: mul_a = '0;
        endcase
    end
    assign sq_total = r_acc + r_prod[31:0];

    // root step, two radicand bits a cycle
    assign sq_t     = {r_rem[22:0], r_rad[RAD_W-1 -: 2]};
    assign sq_trial = {1'b0, r_root, 2'b01};
    assign n_rem    = (sq_t >= sq_trial) ? sq_t - sq_trial : sq_t;
    assign n_root   = {r_root[SQRT_N-2:0], sq_t >= sq_trial};

    assign var_v   = (e32_v > r_prod[43:0]) ? e32_v - r_prod[43:0] : '0;
    assign thr_sum = THR_W'(mean_v) + THR_W'((THR_W'(r_root) * 3) >> 1);
    assign mdiff   = (r_rd.mag > r_mprev) ? r_rd.mag - r_mprev : r_mprev - r_rd.mag;
    assign m_neg   = r_rd.mag < mean_v;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_slot       <= '0;
            r_full       <= 1'b0;
            r_prev_mag   <= '0;
            r_prev_valid <= 1'b0;
            r_thr        <= MAG_W'(THR_RST);
            r_ovalid     <= 1'b0;
            r_oidx       <= '0;
            r_cnt        <= '0;
            r_step       <= '0;
            r_k          <= '0;
            r_v1         <= 1'b0;
            r_v2         <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_data;
            end
            r_v1 <= issue;
            r_v2 <= r_v1 && (r_state == S_WALK1);
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_state <= S_SQ;
                        r_k     <= '0;
                    end
                end
                S_SQ: begin
                    r_k <= r_k + 1'b1;
                    if (r_k == 2'd3) begin
                        r_state <= S_MSQRT;
                        r_step  <= '0;
                    end
                end
                S_MSQRT: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_W'(SQRT_N - 1)) begin
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    r_slot       <= n_slot;
                    r_full       <= n_full;
                    r_prev_mag   <= r_root;
                    r_prev_valid <= 1'b1;
                    r_cnt        <= '0;
                    r_state      <= trigger ? S_WALK1 : S_IDLE;
                end
                S_WALK1: begin
                    if (issue) begin
                        r_cnt <= r_cnt + 1'b1;
                    end else if (!r_v1 && !r_v2) begin
                        r_state <= S_MSQ;
                        r_k     <= '0;
                    end
                end
                S_MSQ: begin
                    r_k <= r_k + 1'b1;
                    if (r_k == 2'd1) begin
                        r_state <= S_SQRT2;
                        r_step  <= '0;
                    end
                end
                S_SQRT2: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_W'(SQRT_N - 1)) begin
                        r_state <= S_THR;
                    end
                end
                S_THR: begin
                    r_state <= S_WALK2;
                    r_cnt   <= '0;
                end
                S_WALK2: begin
                    if (issue) begin
                        r_cnt <= r_cnt + 1'b1;
                    end else if (!r_v1) begin
                        r_state  <= S_OUT;
                        r_ovalid <= 1'b1;
                        r_oidx   <= F_MEAN;
                    end
                end
                S_OUT: begin
                    if (out_acc) begin
                        if (r_oidx == F_ZMEAN) begin
                            r_ovalid <= 1'b0;
                            r_state  <= S_IDLE;
                        end else begin
                            r_oidx <= r_oidx + 1'b1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // window ring
    always_ff @(posedge i_clk) begin
        if (r_state == S_WRITE) begin
            r_mem[r_slot] <= '{x: r_x, y: r_y, z: r_z, mag: r_root};
        end
        r_rd <= r_mem[r_addr];
    end

    // datapath
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_a;
        if (issue) begin
            r_addr <= addr_inc;
        end
        if (r_state == S_MSQRT || r_state == S_SQRT2) begin
            r_rem  <= n_rem;
            r_root <= n_root;
            r_rad  <= {r_rad[RAD_W-3:0], 2'b00};
        end
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    r_x     <= i_accel_x;
                    r_y     <= i_accel_y;
                    r_z     <= i_accel_z;
                    r_roll  <= i_roll_angle;
                    r_pitch <= i_pitch_angle;
                    r_acc   <= '0;
                end
            end
            S_SQ: begin
                if (r_k != 2'd0) begin
                    r_acc <= sq_total;
                end
                if (r_k == 2'd3) begin
                    r_rad  <= {2'b00, sq_total, 10'b0};
                    r_rem  <= '0;
                    r_root <= '0;
                end
            end
            S_WRITE: begin
                r_addr  <= n_slot;
                r_sum   <= '0;
                r_sqs   <= '0;
                r_sma   <= '0;
                r_sx    <= '0;
                r_sy    <= '0;
                r_sz    <= '0;
                r_mstep <= '0;
                r_first <= 1'b1;
            end
            S_WALK1: begin
                if (r_v1) begin
                    r_first <= 1'b0;
                    r_mprev <= r_rd.mag;
                    r_sum   <= r_sum + SUM_W'(r_rd.mag);
                    r_sma   <= r_sma + SMA_W'(abs16(r_rd.x)) + SMA_W'(abs16(r_rd.y))
                             + SMA_W'(abs16(r_rd.z));
                    r_sx    <= r_sx + AX_W'(r_rd.x);
                    r_sy    <= r_sy + AX_W'(r_rd.y);
                    r_sz    <= r_sz + AX_W'(r_rd.z);
                    if (r_first || r_rd.mag > r_max) begin
                        r_max <= r_rd.mag;
                    end
                    if (r_first || r_rd.mag < r_min) begin
                        r_min <= r_rd.mag;
                    end
                    if (!r_first && mdiff > r_mstep) begin
                        r_mstep <= mdiff;
                    end
                end
                // squares of the read magnitudes arrive through the squarer register r_prod, behind the read data
                if (r_v2) begin
                    r_sqs <= r_sqs + SQS_W'(r_prod[2*MAG_W-1:0]);
                end
            end
            S_MSQ: begin
                if (r_k == 2'd1) begin
                    r_rad  <= var_v;
                    r_rem  <= '0;
                    r_root <= '0;
                end
            end
            S_THR: begin
                r_std    <= r_root;
                r_thresh <= (thr_sum < PEAK_FLOOR) ? PEAK_FLOOR : thr_sum;
                r_addr   <= r_slot;
                r_zc     <= '0;
                r_peaks  <= '0;
                r_first  <= 1'b1;
            end
            S_WALK2: begin
                if (r_v1) begin
                    r_first    <= 1'b0;
                    r_prev_neg <= m_neg;
                    if (!r_first && (m_neg != r_prev_neg)) begin
                        r_zc <= r_zc + 1'b1;
                    end
                    if (THR_W'(r_rd.mag) > r_thresh) begin
                        r_peaks <= r_peaks + 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    assign o_in_stall      = (r_state != S_IDLE);
    assign o_out_valid     = r_ovalid;
    assign o_feature_index = r_oidx;
    assign o_last_feature  = (r_oidx == F_ZMEAN);

    always_comb begin
        unique case (r_oidx)
            F_MEAN:   o_feature_value = 32'(mean_v);
            F_STD:    o_feature_value = 32'(r_std);
            F_MAX:    o_feature_value = 32'(r_max);
            F_MIN:    o_feature_value = 32'(r_min);
            F_RANGE:  o_feature_value = 32'(r_max - r_min);
            F_ZCR:    o_feature_value = 32'(zc_prod >> (ZCR_SH - 16));
            F_SMA:    o_feature_value = 32'({r_sma, 5'b0} >> LW);
            F_PEAKS:  o_feature_value = 32'(r_peaks) << 16;
            F_PKAMP:  o_feature_value = 32'(r_max - r_min);
            F_STEP:   o_feature_value = 32'(r_mstep);
            F_ENERGY: o_feature_value = 32'(e32_v[2*MAG_W-1:16]);
            F_ROLL:   o_feature_value = 32'(r_roll);
            F_PITCH:  o_feature_value = 32'(r_pitch);
            F_XMEAN:  o_feature_value = 32'($signed({r_sx, 5'b0}) >>> LW);
            F_YMEAN:  o_feature_value = 32'($signed({r_sy, 5'b0}) >>> LW);
            default:  o_feature_value = 32'($signed({r_sz, 5'b0}) >>> LW);
        endcase
    end

endmodule

`default_nettype wire
